// ===== src/bsm_pkg.sv =====
`timescale 1ns / 1ps
package bsm_pkg;

  // Field widths.
  localparam int CW    = 32;          // coordinate width
  localparam int RW    = CW - 1;      // radius width
  localparam int EPSW  = 16;          // epsilon register width
  // Derived datapath widths.
  localparam int DW    = CW + 1;      // center difference, signed
  localparam int MW    = CW;          // difference magnitude
  localparam int SW    = 2 * MW + 2;  // sum of three squares
  localparam int SRW   = SW / 2;      // square root width, one cell per bit
  localparam int SREMW = SRW + 1;     // square root remainder
  localparam int DIVW  = SRW + 1;     // divisor, twice the distance
  localparam int QW    = MW;          // quotient, never above the magnitude
  localparam int GLW   = 17;          // low slice of the growth operand
  localparam int GHW   = SRW - GLW;   // high slice of the growth operand
  localparam int NUMW  = QW + DIVW + 1; // rounded dividend

  typedef enum logic [1:0] {
    KASE_BLEND  = 2'd0,
    KASE_CONC   = 2'd1,
    KASE_FIRST  = 2'd2,
    KASE_SECOND = 2'd3
  } kase_t;

  // Word context that rides along the square root chain.
  typedef struct packed {
    logic [2:0][CW-1:0] c1;
    logic [2:0][CW-1:0] c2;
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
    logic [RW-1:0]      r1;
    logic [RW-1:0]      r2;
  } sq_ctx_t;

  // Word context that rides along the divider chain.
  typedef struct packed {
    logic [2:0][CW-1:0] base;
    logic [2:0]         neg;
    logic               use_q;
    logic [RW-1:0]      radius;
    kase_t              kase;
    logic [DIVW-1:0]    dvs;
  } dv_ctx_t;

endpackage

// ===== src/bounding_sphere_merge_top.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle; a 33-cell square root chain and a 32-cell divider
// chain each retire one bit per cell per cycle.
// The whole pipeline advances together and holds while a result waits on out_stall.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets eps_r to 66.
module bounding_sphere_merge_top import bsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [EPSW-1:0]      cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_first_x,
  input  logic signed [CW-1:0] in_first_y,
  input  logic signed [CW-1:0] in_first_z,
  input  logic [RW-1:0]        in_first_radius,
  input  logic signed [CW-1:0] in_second_x,
  input  logic signed [CW-1:0] in_second_y,
  input  logic signed [CW-1:0] in_second_z,
  input  logic [RW-1:0]        in_second_radius,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_merged_x,
  output logic signed [CW-1:0] out_merged_y,
  output logic signed [CW-1:0] out_merged_z,
  output logic [RW-1:0]        out_merged_radius,
  output logic [1:0]           out_case_taken
);

  localparam logic [RW-1:0] RMAX = {RW{1'b1}};

  logic en;
  logic out_valid_r;
  logic [EPSW-1:0] eps_r;

  // Pipeline advances unless a finished word is held by the consumer.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPSW'(66);
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // Input capture.
  logic               v0_r;
  logic [2:0][CW-1:0] c1_0_r, c2_0_r;
  logic [RW-1:0]      r1_0_r, r2_0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_0_r <= {in_first_z, in_first_y, in_first_x};
      c2_0_r <= {in_second_z, in_second_y, in_second_x};
      r1_0_r <= in_first_radius;
      r2_0_r <= in_second_radius;
    end
  end

  // Center differences as sign and magnitude.
  logic               v1_r;
  sq_ctx_t            ctx1_r, ctx1_nxt;
  logic [2:0][DW-1:0] delta, dabs;

  always_comb begin
    ctx1_nxt.c1 = c1_0_r;
    ctx1_nxt.c2 = c2_0_r;
    ctx1_nxt.r1 = r1_0_r;
    ctx1_nxt.r2 = r2_0_r;
    for (int k = 0; k < 3; k++) begin
      delta[k] = {c2_0_r[k][CW-1], c2_0_r[k]} - {c1_0_r[k][CW-1], c1_0_r[k]};
      dabs[k]  = delta[k][DW-1] ? (~delta[k] + DW'(1)) : delta[k];
      ctx1_nxt.neg[k] = delta[k][DW-1];
      ctx1_nxt.mag[k] = dabs[k][MW-1:0];
    end
  end

  // Squares, then their sum.
  logic                 v2_r, v3_r;
  sq_ctx_t              ctx2_r, ctx3_r;
  logic [2:0][2*MW-1:0] sqp_r;
  logic [SW-1:0]        sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx1_nxt;
      ctx2_r <= ctx1_r;
      for (int k = 0; k < 3; k++) begin
        sqp_r[k] <= ctx1_r.mag[k] * ctx1_r.mag[k];
      end
      ctx3_r <= ctx2_r;
      sum_r  <= SW'(sqp_r[0]) + SW'(sqp_r[1]) + SW'(sqp_r[2]);
    end
  end

  // Square root chain, two radicand bits per cell.
  logic             sv   [SRW+1];
  logic [SW-1:0]    srad [SRW+1];
  logic [SRW-1:0]   sroot[SRW+1];
  logic [SREMW-1:0] srem [SRW+1];
  sq_ctx_t          sctx [SRW+1];

  assign sv[0]    = v3_r;
  assign srad[0]  = sum_r;
  assign sroot[0] = '0;
  assign srem[0]  = '0;
  assign sctx[0]  = ctx3_r;

  for (genvar i = 0; i < SRW; i++) begin : g_sqrt
    bsm_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sv[i]),
      .rad_i  (srad[i]),
      .root_i (sroot[i]),
      .rem_i  (srem[i]),
      .ctx_i  (sctx[i]),
      .v_o    (sv[i+1]),
      .rad_o  (srad[i+1]),
      .root_o (sroot[i+1]),
      .rem_o  (srem[i+1]),
      .ctx_o  (sctx[i+1])
    );
  end

  // Case decision and blended radius.
  sq_ctx_t        sc;
  logic [SRW:0]   de, r1e, r2e, rsum;
  logic [SRW-1:0] rr, grow_nxt;
  logic           conc, first_enc, second_enc;
  dv_ctx_t        dctx_nxt;

  always_comb begin
    sc         = sctx[SRW];
    de         = {1'b0, sroot[SRW]};
    r1e        = (SRW+1)'(sc.r1);
    r2e        = (SRW+1)'(sc.r2);
    rsum       = r1e + r2e + de;
    rr         = rsum[SRW:1];
    grow_nxt   = rr - SRW'(sc.r1);
    conc       = (sroot[SRW] < SRW'(eps_r));
    first_enc  = ((r2e + de) < r1e);
    second_enc = ((r1e + de) < r2e);

    dctx_nxt.neg   = sc.neg;
    dctx_nxt.dvs   = {sroot[SRW], 1'b0};
    dctx_nxt.base  = sc.c1;
    dctx_nxt.use_q = 1'b0;
    if (conc) begin
      dctx_nxt.kase   = KASE_CONC;
      dctx_nxt.radius = (sc.r1 > sc.r2) ? sc.r1 : sc.r2;
    end else if (first_enc) begin
      dctx_nxt.kase   = KASE_FIRST;
      dctx_nxt.radius = sc.r1;
    end else if (second_enc) begin
      dctx_nxt.kase   = KASE_SECOND;
      dctx_nxt.radius = sc.r2;
      dctx_nxt.base   = sc.c2;
    end else begin
      dctx_nxt.kase   = KASE_BLEND;
      dctx_nxt.radius = (rr > SRW'(RMAX)) ? RMAX : rr[RW-1:0];
      dctx_nxt.use_q  = (sroot[SRW] != '0);
    end
  end

  logic               vd_r, vm1_r, vm2_r;
  dv_ctx_t            dctx_r, dctx_m1_r, dctx_m2_r;
  logic [SRW-1:0]     grow_r, d_r, d_m1_r;
  logic [2:0][MW-1:0] mag_d_r;
  logic [2:0][GLW+MW-1:0] pl_r;
  logic [2:0][GHW+MW-1:0] ph_r;
  logic [2:0][NUMW-1:0]   num;
  logic [2:0][DIVW-1:0]   rem0_r;
  logic [2:0][QW-1:0]     nlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r  <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
    end else if (en) begin
      vd_r  <= sv[SRW];
      vm1_r <= vd_r;
      vm2_r <= vm1_r;
    end
  end

  // Growth times magnitude in two slices, then the rounded dividend.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {(NUMW-1)'({ph_r[k], {GLW{1'b0}}}) + (NUMW-1)'(pl_r[k]), 1'b0}
             + NUMW'(d_m1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dctx_r    <= dctx_nxt;
      grow_r    <= grow_nxt;
      d_r       <= sroot[SRW];
      mag_d_r   <= sc.mag;
      dctx_m1_r <= dctx_r;
      d_m1_r    <= d_r;
      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= grow_r[GLW-1:0] * mag_d_r[k];
        ph_r[k] <= grow_r[SRW-1:GLW] * mag_d_r[k];
      end
      dctx_m2_r <= dctx_m1_r;
      for (int k = 0; k < 3; k++) begin
        rem0_r[k] <= num[k][QW +: DIVW];
        nlo_r[k]  <= num[k][QW-1:0];
      end
    end
  end

  // Divider chain, one quotient bit per cell.
  logic                 dv   [QW+1];
  logic [2:0][DIVW-1:0] drem [QW+1];
  logic [2:0][QW-1:0]   dnum [QW+1];
  logic [2:0][QW-1:0]   dq   [QW+1];
  dv_ctx_t              dcx  [QW+1];

  assign dv[0]   = vm2_r;
  assign drem[0] = rem0_r;
  assign dnum[0] = nlo_r;
  assign dq[0]   = '0;
  assign dcx[0]  = dctx_m2_r;

  for (genvar i = 0; i < QW; i++) begin : g_div
    bsm_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (dv[i]),
      .rem_i (drem[i]),
      .num_i (dnum[i]),
      .q_i   (dq[i]),
      .ctx_i (dcx[i]),
      .v_o   (dv[i+1]),
      .rem_o (drem[i+1]),
      .num_o (dnum[i+1]),
      .q_o   (dq[i+1]),
      .ctx_o (dcx[i+1])
    );
  end

  // Apply the signed offset and register the result word.
  dv_ctx_t            fc;
  logic [2:0][CW-1:0] off, res;
  logic [2:0][CW-1:0] out_c_r;
  logic [RW-1:0]      out_rad_r;
  kase_t              out_kase_r;

  always_comb begin
    fc = dcx[QW];
    for (int k = 0; k < 3; k++) begin
      off[k] = fc.neg[k] ? (CW'(0) - CW'(dq[QW][k])) : CW'(dq[QW][k]);
      res[k] = fc.use_q ? (fc.base[k] + off[k]) : fc.base[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c_r    <= res;
      out_rad_r  <= fc.radius;
      out_kase_r <= fc.kase;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_merged_x      = out_c_r[0];
  assign out_merged_y      = out_c_r[1];
  assign out_merged_z      = out_c_r[2];
  assign out_merged_radius = out_rad_r;
  assign out_case_taken    = out_kase_r;

  // The input side stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // Only a blended word with nonzero distance takes the quotient.
  a_useq_blend: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r && dctx_r.use_q) |-> (dctx_r.kase == KASE_BLEND && d_r != '0))
    else $error("quotient selected outside the blended case");

  // A held result word keeps its case code.
  a_hold_case: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_case_taken)))
    else $error("held result changed");

endmodule

// ===== src/bsm_sqrt_cell.sv =====
`timescale 1ns / 1ps
module bsm_sqrt_cell import bsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [SW-1:0]    rad_i,
  input  logic [SRW-1:0]   root_i,
  input  logic [SREMW-1:0] rem_i,
  input  sq_ctx_t          ctx_i,
  output logic             v_o,
  output logic [SW-1:0]    rad_o,
  output logic [SRW-1:0]   root_o,
  output logic [SREMW-1:0] rem_o,
  output sq_ctx_t          ctx_o
);

  logic [SREMW+1:0] remx, trial, diff;
  logic             ge;
  logic             v_r;
  logic [SW-1:0]    rad_r, rad_nxt;
  logic [SRW-1:0]   root_r, root_nxt;
  logic [SREMW-1:0] rem_r, rem_nxt;
  sq_ctx_t          ctx_r;

  // One restoring step: bring in two radicand bits, try the next root bit.
  always_comb begin
    remx     = {rem_i, rad_i[SW-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    diff     = remx - trial;
    ge       = (remx >= trial);
    rad_nxt  = {rad_i[SW-3:0], 2'b00};
    root_nxt = {root_i[SRW-2:0], ge};
    rem_nxt  = ge ? diff[SREMW-1:0] : remx[SREMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      ctx_r  <= ctx_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
  assign ctx_o  = ctx_r;

endmodule

// ===== src/bsm_div_cell.sv =====
`timescale 1ns / 1ps
module bsm_div_cell import bsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  logic [2:0][DIVW-1:0]  rem_i,
  input  logic [2:0][QW-1:0]    num_i,
  input  logic [2:0][QW-1:0]    q_i,
  input  dv_ctx_t               ctx_i,
  output logic                  v_o,
  output logic [2:0][DIVW-1:0]  rem_o,
  output logic [2:0][QW-1:0]    num_o,
  output logic [2:0][QW-1:0]    q_o,
  output dv_ctx_t               ctx_o
);

  logic [2:0][DIVW:0]   remx, diff;
  logic [2:0]           ge;
  logic                 v_r;
  logic [2:0][DIVW-1:0] rem_r, rem_nxt;
  logic [2:0][QW-1:0]   num_r, num_nxt;
  logic [2:0][QW-1:0]   q_r, q_nxt;
  dv_ctx_t              ctx_r;

  // One quotient bit per lane; the three axes share the divisor.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      remx[k]    = {rem_i[k], num_i[k][QW-1]};
      diff[k]    = remx[k] - {1'b0, ctx_i.dvs};
      ge[k]      = (remx[k] >= {1'b0, ctx_i.dvs});
      rem_nxt[k] = ge[k] ? diff[k][DIVW-1:0] : remx[k][DIVW-1:0];
      num_nxt[k] = {num_i[k][QW-2:0], 1'b0};
      q_nxt[k]   = {q_i[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      q_r   <= q_nxt;
      ctx_r <= ctx_i;
    end
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign num_o = num_r;
  assign q_o   = q_r;
  assign ctx_o = ctx_r;

endmodule
